### rtl/cvs_pkg.sv
// shared types, constants and sigmoid table for the convolution unit
package cvs_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_KERNEL  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_COUNT   = MAX_KERNEL * MAX_KERNEL;
  localparam int HIST_DEPTH  = MAX_KERNEL - 1;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int LINE_BITS   = HIST_DEPTH * SAMPLE_BITS;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int ROW_BITS    = PROD_BITS + 3;
  localparam int ACC_BITS    = PROD_BITS + 8;
  localparam int Q_BITS      = ACC_BITS - 12;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_TAP   = 2'd1,
    OP_BIAS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_KERNEL_WIDTH  = 2'd2,
    REG_KERNEL_HEIGHT = 2'd3
  } reg_idx_t;

  typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_t;
  typedef logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] taps_t;
  typedef logic [255:0][15:0] sig_tab_t;

  // window position and sizes that travel with one pixel
  typedef struct packed {
    logic [2:0] kw;
    logic [2:0] kh;
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } pos_t;

  // unsigned long division by shift and subtract, only used to build the table
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(65535 / (1 + e^(k/16))), half up, in 40-bit fraction fixed point
  function automatic logic [15:0] sig_of_neg(input logic [7:0] k);
    logic [63:0] one;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] n2;
    one  = 64'd1 << 40;
    term = one;
    e    = one;
    for (int n = 1; n <= 80; n++) begin
      term = udiv64(term * 64'(k), 64'd16 * 64'(n));
      e    = e + term;
    end
    d  = e + one;
    n2 = (64'd65535 << 40) * 64'd2;
    return 16'(udiv64(n2 + d, 64'd2 * d));
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t   t;
    logic [15:0] v;
    t[128] = sig_of_neg(8'd0);
    for (int k = 1; k <= 128; k++) begin
      v = sig_of_neg(8'(k));
      t[128 - k] = v;
      if (k <= 127) t[128 + k] = 16'(16'd65535 - v);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

### rtl/conv2d_valid_sigmoid_unit.sv
// top level of the streaming valid convolution with sigmoid activation
// - input stream in_*: one transfer per item; in_tuser carries op, in_tdata carries
//   tap_index and sample_value. op pixel feeds the raster stream, op tap and op bias
//   load the kernel taps and the bias, and op none is dropped
// - result stream out_*: one transfer per pixel that completes a full window;
//   out_tdata carries pre_activation, activation, out_row and out_col, out_tlast
//   marks the last window of the frame
// - the apb port holds image width, image height, kernel width and kernel height
//   at byte addresses 0, 4, 8 and 12; write only while the stream is idle
// - throughput is one item per cycle while out_tready does not hold the pipe; an
//   input transfer passes line store read, window update, multiply, row sums,
//   total with rounding and table lookup before its result is valid
// - the line store is one ram word per column holding the last four rows; a
//   pixel reads its column at acceptance and writes it back from stage one,
//   and a one-column image is served by forwarding the word being written
// - reset clears counters, window, taps and bias and sets the sizes to 28, 28,
//   5, 5; the line store is not cleared, so no warm-up pass is needed
// - when out_tready is low with a result waiting, the whole pipe holds and
//   in_tready drops in the same cycle
module conv2d_valid_sigmoid_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // op
  input  logic [23:0] in_tdata,    // tap_index [4:0], sample_value [20:5]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // pre_activation, activation, out_row, out_col
  output logic        out_tlast,   // last_of_frame
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [8:0] img_w_r, img_h_r;
  logic [2:0] ker_w_r, ker_h_r;
  logic       cfg_wr;
  cvs_pkg::reg_idx_t cfg_idx;

  // clamped sizes
  logic [8:0] wc, hc;
  logic [2:0] kwc, khc, kw_lim, kh_lim;
  logic [7:0] wm1, hm1;

  // pipeline control
  logic en, accept;

  cvs_pkg::win_t  win;
  cvs_pkg::taps_t taps;
  logic [cvs_pkg::SAMPLE_BITS-1:0] bias;
  logic           mac_valid;
  cvs_pkg::pos_t  mac_pos;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cvs_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 9'd28;
      img_h_r <= 9'd28;
      ker_w_r <= 3'd5;
      ker_h_r <= 3'd5;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cvs_pkg::REG_IMAGE_WIDTH:   img_w_r <= cfg_pwdata[8:0];
        cvs_pkg::REG_IMAGE_HEIGHT:  img_h_r <= cfg_pwdata[8:0];
        cvs_pkg::REG_KERNEL_WIDTH:  ker_w_r <= cfg_pwdata[2:0];
        cvs_pkg::REG_KERNEL_HEIGHT: ker_h_r <= cfg_pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cvs_pkg::REG_IMAGE_WIDTH:   cfg_prdata = {23'd0, img_w_r};
      cvs_pkg::REG_IMAGE_HEIGHT:  cfg_prdata = {23'd0, img_h_r};
      cvs_pkg::REG_KERNEL_WIDTH:  cfg_prdata = {29'd0, ker_w_r};
      cvs_pkg::REG_KERNEL_HEIGHT: cfg_prdata = {29'd0, ker_h_r};
    endcase
  end

  // zero acts as one, sizes above the limits act as the limits,
  // kernel never larger than the image
  always_comb begin
    wc     = (img_w_r == 9'd0) ? 9'd1 :
             (img_w_r > 9'(cvs_pkg::MAX_WIDTH)) ? 9'(cvs_pkg::MAX_WIDTH) : img_w_r;
    hc     = (img_h_r == 9'd0) ? 9'd1 : (img_h_r > 9'd256) ? 9'd256 : img_h_r;
    kw_lim = (ker_w_r == 3'd0) ? 3'd1 :
             (ker_w_r > 3'(cvs_pkg::MAX_KERNEL)) ? 3'(cvs_pkg::MAX_KERNEL) : ker_w_r;
    kh_lim = (ker_h_r == 3'd0) ? 3'd1 :
             (ker_h_r > 3'(cvs_pkg::MAX_KERNEL)) ? 3'(cvs_pkg::MAX_KERNEL) : ker_h_r;
    kwc    = ({6'd0, kw_lim} > wc) ? wc[2:0] : kw_lim;
    khc    = ({6'd0, kh_lim} > hc) ? hc[2:0] : kh_lim;
    wm1    = 8'(wc - 9'd1);
    hm1    = 8'(hc - 9'd1);
  end

  // the pipe moves whenever the output register is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  cvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .accept   (accept),
    .op       (in_tuser),
    .tap_index(in_tdata[4:0]),
    .sample   (in_tdata[20:5]),
    .wm1      (wm1),
    .hm1      (hm1),
    .kw       (kwc),
    .kh       (khc),
    .win      (win),
    .taps     (taps),
    .bias     (bias),
    .mac_valid(mac_valid),
    .mac_pos  (mac_pos)
  );

  cvs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .win      (win),
    .taps     (taps),
    .bias     (bias),
    .mac_valid(mac_valid),
    .mac_pos  (mac_pos),
    .out_valid(out_tvalid),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

endmodule

### rtl/cvs_ram.sv
// generic single-write, single-read ram with registered read data
module cvs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/cvs_front.sv
// raster counters, line store read-modify-write, window and tap registers
module cvs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 accept,
  input  logic [1:0]                           op,
  input  logic [4:0]                           tap_index,
  input  logic [cvs_pkg::SAMPLE_BITS-1:0]      sample,
  input  logic [7:0]                           wm1,
  input  logic [7:0]                           hm1,
  input  logic [2:0]                           kw,
  input  logic [2:0]                           kh,
  output cvs_pkg::win_t                        win,
  output cvs_pkg::taps_t                       taps,
  output logic [cvs_pkg::SAMPLE_BITS-1:0]      bias,
  output logic                                 mac_valid,
  output cvs_pkg::pos_t                        mac_pos
);

  localparam int SB = cvs_pkg::SAMPLE_BITS;
  localparam int K  = cvs_pkg::MAX_KERNEL;
  localparam int HD = cvs_pkg::HIST_DEPTH;

  logic [7:0] col_r, row_r;
  logic [7:0] c, r;
  logic       emit;
  cvs_pkg::pos_t pos;

  logic                      s1_valid_r;
  logic [1:0]                s1_op_r;
  logic [4:0]                s1_tap_r;
  logic [SB-1:0]             s1_val_r;
  logic [7:0]                s1_c_r;
  logic                      s1_emit_r;
  cvs_pkg::pos_t             s1_pos_r;
  logic                      fwd_r;
  logic [cvs_pkg::LINE_BITS-1:0] fwd_data_r;

  logic [cvs_pkg::LINE_BITS-1:0] rdata, hist, wword;
  logic [K-1:0][SB-1:0]      vcol;
  logic                      s1_pix;
  logic [1:0]                hsel;

  cvs_pkg::win_t             win_r;
  cvs_pkg::taps_t            taps_r;
  logic [SB-1:0]             bias_r;
  logic                      mac_valid_r;
  cvs_pkg::pos_t             mac_pos_r;

  // position of the arriving pixel, counters past the size act as last
  always_comb begin
    c    = (col_r < wm1) ? col_r : wm1;
    r    = (row_r < hm1) ? row_r : hm1;
    emit = ({1'b0, r} + 9'd1 >= {6'd0, kh}) && ({1'b0, c} + 9'd1 >= {6'd0, kw});
    pos.kw   = kw;
    pos.kh   = kh;
    pos.row  = 8'(r + 8'd1 - {5'd0, kh});
    pos.col  = 8'(c + 8'd1 - {5'd0, kw});
    pos.last = (c == wm1) && (r == hm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && op == cvs_pkg::OP_PIXEL) begin
      if (c >= wm1) begin
        col_r <= '0;
        row_r <= (r >= hm1) ? 8'd0 : 8'(r + 8'd1);
      end else begin
        col_r <= 8'(c + 8'd1);
        row_r <= r;
      end
    end
  end

  assign s1_pix = s1_valid_r && (s1_op_r == cvs_pkg::OP_PIXEL);

  cvs_ram #(
    .WIDTH(cvs_pkg::LINE_BITS),
    .DEPTH(cvs_pkg::MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (en && s1_pix),
    .waddr(s1_c_r),
    .wdata(wword),
    .re   (accept),
    .raddr(c),
    .rdata(rdata)
  );

  // newest row in the low slot, older rows above
  always_comb begin
    hist  = fwd_r ? fwd_data_r : rdata;
    wword = {hist[(HD-1)*SB-1:0], s1_val_r};
    hsel  = '0;
    for (int fh = 0; fh < K; fh++) begin
      vcol[fh] = '0;
      if (3'(fh) + 3'd1 < s1_pos_r.kh) begin
        hsel     = 2'(s1_pos_r.kh - 3'd2 - 3'(fh));
        vcol[fh] = hist[hsel*SB +: SB];
      end else if (3'(fh) + 3'd1 == s1_pos_r.kh) begin
        vcol[fh] = s1_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      mac_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= accept;
      mac_valid_r <= s1_pix && s1_emit_r;
    end
  end

  // payload of stage one; forward the word being written to the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op;
      s1_tap_r   <= tap_index;
      s1_val_r   <= sample;
      s1_c_r     <= c;
      s1_emit_r  <= emit;
      s1_pos_r   <= pos;
      fwd_r      <= s1_pix && (s1_c_r == c);
      fwd_data_r <= wword;
    end
    if (en) mac_pos_r <= s1_pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      taps_r <= '0;
      bias_r <= '0;
    end else if (en && s1_valid_r) begin
      unique case (s1_op_r)
        cvs_pkg::OP_PIXEL: begin
          for (int fh = 0; fh < K; fh++) begin
            for (int j = 0; j < K - 1; j++) win_r[fh][j] <= win_r[fh][j+1];
            win_r[fh][K-1] <= vcol[fh];
          end
        end
        cvs_pkg::OP_TAP: begin
          if (s1_tap_r < 5'(cvs_pkg::TAP_COUNT)) taps_r[s1_tap_r] <= s1_val_r;
        end
        cvs_pkg::OP_BIAS: bias_r <= s1_val_r;
        default: ;
      endcase
    end
  end

  assign win       = win_r;
  assign taps      = taps_r;
  assign bias      = bias_r;
  assign mac_valid = mac_valid_r;
  assign mac_pos   = mac_pos_r;

endmodule

### rtl/cvs_back.sv
// multiply, adder tree, rounding and sigmoid lookup, then the output register
module cvs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  cvs_pkg::win_t                   win,
  input  cvs_pkg::taps_t                  taps,
  input  logic [cvs_pkg::SAMPLE_BITS-1:0] bias,
  input  logic                            mac_valid,
  input  cvs_pkg::pos_t                   mac_pos,
  output logic                            out_valid,
  output logic [63:0]                     out_data,
  output logic                            out_last
);

  localparam int K  = cvs_pkg::MAX_KERNEL;
  localparam int PB = cvs_pkg::PROD_BITS;
  localparam int RB = cvs_pkg::ROW_BITS;
  localparam int AB = cvs_pkg::ACC_BITS;
  localparam int QB = cvs_pkg::Q_BITS;

  logic [K-1:0][K-1:0][PB-1:0] prod, prod_r;
  logic [cvs_pkg::SAMPLE_BITS-1:0] p_bias_r;
  logic          p_valid_r;
  cvs_pkg::pos_t p_pos_r;

  logic [K-1:0][RB-1:0] rsum, rsum_r;
  logic [cvs_pkg::SAMPLE_BITS-1:0] s_bias_r;
  logic          s_valid_r;
  cvs_pkg::pos_t s_pos_r;

  logic [AB-1:0] acc;
  logic [QB-1:0] q;
  logic [31:0]   pre, pre_r;
  logic [7:0]    idx, idx_r;
  logic          t_valid_r;
  cvs_pkg::pos_t t_pos_r;

  logic          out_valid_r;
  logic [63:0]   out_data_r;
  logic          out_last_r;

  logic [4:0] ti;
  logic [2:0] wc;

  always_comb begin
    ti = '0;
    wc = '0;
    for (int fh = 0; fh < K; fh++) begin
      for (int fw = 0; fw < K; fw++) begin
        prod[fh][fw] = '0;
        if (3'(fh) < mac_pos.kh && 3'(fw) < mac_pos.kw) begin
          ti = 5'(5'(fh) * {2'd0, mac_pos.kw} + 5'(fw));
          wc = 3'(3'(K) - mac_pos.kw + 3'(fw));
          prod[fh][fw] = PB'($signed(taps[ti]) * $signed(win[fh][wc]));
        end
      end
    end
  end

  always_comb begin
    for (int fh = 0; fh < K; fh++) begin
      rsum[fh] = '0;
      for (int fw = 0; fw < K; fw++)
        rsum[fh] = RB'($signed(rsum[fh]) + $signed(prod_r[fh][fw]));
    end
  end

  // exact q.24 sum, round half up to q.12 by floor after adding half
  always_comb begin
    acc = AB'($signed({{(AB-cvs_pkg::SAMPLE_BITS-12){s_bias_r[cvs_pkg::SAMPLE_BITS-1]}},
                       s_bias_r, 12'd0})) + AB'(2048);
    for (int fh = 0; fh < K; fh++)
      acc = AB'($signed(acc) + $signed(rsum_r[fh]));
    q   = acc[AB-1:12];
    pre = 32'($signed(q));
    if (q[QB-1:15] == '0 || q[QB-1:15] == '1) idx = {~q[15], q[14:8]};
    else if (q[QB-1]) idx = 8'd0;
    else idx = 8'd255;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      t_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r   <= mac_valid;
      s_valid_r   <= p_valid_r;
      t_valid_r   <= s_valid_r;
      out_valid_r <= t_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= prod;
      p_bias_r   <= bias;
      p_pos_r    <= mac_pos;
      rsum_r     <= rsum;
      s_bias_r   <= p_bias_r;
      s_pos_r    <= p_pos_r;
      pre_r      <= pre;
      idx_r      <= idx;
      t_pos_r    <= s_pos_r;
      out_data_r <= {t_pos_r.col, t_pos_r.row, cvs_pkg::SIG_TABLE[idx_r], pre_r};
      out_last_r <= t_pos_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule
